FILE: hdl/point_segment_distance_defines.svh
// ============================================================================
// Assertion macros for the point-to-segment distance block
// Shared concurrent assertion forms, clocked on i_clk.
// ============================================================================
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH

// assertion that is off while reset is held
`define PSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// assertion that also holds across reset
`define PSD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: hdl/psd_pkg.sv
// ============================================================================
// psd_pkg
// Widths and shared types of the point-to-segment distance pipeline.
// ============================================================================
package psd_pkg;
    localparam int CW     = 16;        // coordinate width
    localparam int DW     = CW + 1;    // coordinate difference width
    localparam int PW     = 2 * DW;    // product / squared length width
    localparam int NW     = 2 * PW;    // dividend width (cross squared)
    localparam int QW     = PW;        // quotient (squared distance) width
    localparam int RW     = QW / 2;    // root width
    localparam int DIST_W = 17;        // distance field width

    typedef struct packed {
        logic vld;
        logic hit;
    } t_ctl;
endpackage

FILE: hdl/psd_front.sv
// ============================================================================
// psd_front
// Differences, products, sums, branch choice and dividend build (5 stages).
// ============================================================================
module psd_front import psd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic                 i_line_mode,
    input  logic [CW-1:0]        i_px,
    input  logic [CW-1:0]        i_py,
    input  logic [CW-1:0]        i_ax,
    input  logic [CW-1:0]        i_ay,
    input  logic [CW-1:0]        i_bx,
    input  logic [CW-1:0]        i_by,
    output t_ctl                 o_ctl,
    output logic [NW-1:0]        o_num,
    output logic [PW-1:0]        o_den
);
    logic [4:0] r_vld;

    // stage 1: differences
    logic signed [DW-1:0] r_apx, r_apy, r_bpx, r_bpy, r_abx, r_aby;
    logic                 r_mode1;
    // stage 2: products
    logic signed [PW-1:0] r_abxx, r_abyy, r_apxx, r_apyy, r_bpxx, r_bpyy;
    logic signed [PW-1:0] r_dx, r_dy, r_cx, r_cy;
    logic                 r_mode2;
    // stage 3: sums
    logic signed [PW:0]   r_len2, r_ap2, r_bp2, r_dot, r_cross;
    logic                 r_mode3;
    // stage 4: branch and partial squares of |cross|
    logic                 r_perp;
    logic [PW-1:0]        r_hh, r_hl, r_ll, r_len4, r_minsq;
    // stage 5: dividend / divisor
    logic [NW-1:0]        r_num;
    logic [PW-1:0]        r_den;
    logic                 r_hit;

    logic signed [DW-1:0] n_px, n_py, n_ax, n_ay, n_bx, n_by;
    logic signed [PW:0]   n_cmag_s;
    logic [PW-1:0]        n_cmag;
    logic                 n_perp;

    assign n_px = signed'({i_px[CW-1], i_px});
    assign n_py = signed'({i_py[CW-1], i_py});
    assign n_ax = signed'({i_ax[CW-1], i_ax});
    assign n_ay = signed'({i_ay[CW-1], i_ay});
    assign n_bx = signed'({i_bx[CW-1], i_bx});
    assign n_by = signed'({i_by[CW-1], i_by});

    assign n_cmag_s = r_cross[PW] ? -r_cross : r_cross;
    assign n_cmag   = n_cmag_s[PW-1:0];
    // foot strictly inside the segment, or line mode; degenerate segment never
    assign n_perp   = (r_len2 != '0) &&
                      (r_mode3 || ((r_dot > 0) && (r_dot < r_len2)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_apx   <= n_px - n_ax;
            r_apy   <= n_py - n_ay;
            r_bpx   <= n_px - n_bx;
            r_bpy   <= n_py - n_by;
            r_abx   <= n_bx - n_ax;
            r_aby   <= n_by - n_ay;
            r_mode1 <= i_line_mode;

            r_abxx  <= r_abx * r_abx;
            r_abyy  <= r_aby * r_aby;
            r_apxx  <= r_apx * r_apx;
            r_apyy  <= r_apy * r_apy;
            r_bpxx  <= r_bpx * r_bpx;
            r_bpyy  <= r_bpy * r_bpy;
            r_dx    <= r_apx * r_abx;
            r_dy    <= r_apy * r_aby;
            r_cx    <= r_apx * r_aby;
            r_cy    <= r_apy * r_abx;
            r_mode2 <= r_mode1;

            r_len2  <= {r_abxx[PW-1], r_abxx} + {r_abyy[PW-1], r_abyy};
            r_ap2   <= {r_apxx[PW-1], r_apxx} + {r_apyy[PW-1], r_apyy};
            r_bp2   <= {r_bpxx[PW-1], r_bpxx} + {r_bpyy[PW-1], r_bpyy};
            r_dot   <= {r_dx[PW-1], r_dx} + {r_dy[PW-1], r_dy};
            r_cross <= {r_cx[PW-1], r_cx} - {r_cy[PW-1], r_cy};
            r_mode3 <= r_mode2;

            r_perp  <= n_perp;
            r_hh    <= n_cmag[PW-1:DW] * n_cmag[PW-1:DW];
            r_hl    <= n_cmag[PW-1:DW] * n_cmag[DW-1:0];
            r_ll    <= n_cmag[DW-1:0] * n_cmag[DW-1:0];
            r_len4  <= r_len2[PW-1:0];
            // floor-sqrt is monotonic: nearer end point = smaller square
            r_minsq <= (r_ap2 < r_bp2) ? r_ap2[PW-1:0] : r_bp2[PW-1:0];

            r_num   <= r_perp ? ({r_hh, {PW{1'b0}}} + (NW'(r_hl) << (DW + 1)) + NW'(r_ll))
                              : NW'(r_minsq);
            r_den   <= r_perp ? r_len4 : PW'(1);
            r_hit   <= r_perp;
        end
    end

    assign o_ctl = '{vld: r_vld[4], hit: r_hit};
    assign o_num = r_num;
    assign o_den = r_den;
endmodule

FILE: hdl/psd_div.sv
// ============================================================================
// psd_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module psd_div import psd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_ctl             i_ctl,
    input  logic [NW-1:0]    i_num,
    input  logic [PW-1:0]    i_den,
    output t_ctl             o_ctl,
    output logic [QW-1:0]    o_quo
);
    // quotient fits QW bits, so the top part starts below the divisor
    logic [PW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_low [0:QW];
    logic [QW-1:0] r_quo [0:QW];
    logic [PW-1:0] r_den [0:QW];
    logic          r_hit [0:QW];
    logic [QW:0]   r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-1:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[NW-1:QW];
            r_low[0] <= i_num[QW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_hit[0] <= i_ctl.hit;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [PW:0] n_try;
        logic        n_ge;
        logic [PW:0] n_sub;
        assign n_try = {r_rem[k], r_low[k][QW-1]};
        assign n_ge  = n_try >= {1'b0, r_den[k]};
        assign n_sub = n_try - {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_ge ? n_sub[PW-1:0] : n_try[PW-1:0];
                r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
                r_quo[k+1] <= {r_quo[k][QW-2:0], n_ge};
                r_den[k+1] <= r_den[k];
                r_hit[k+1] <= r_hit[k];
            end
        end
    end

    assign o_ctl = '{vld: r_vld[QW], hit: r_hit[QW]};
    assign o_quo = r_quo[QW];
endmodule

FILE: hdl/psd_sqrt.sv
// ============================================================================
// psd_sqrt
// Pipelined integer square root, one root bit per stage.
// ============================================================================
module psd_sqrt import psd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_ctl             i_ctl,
    input  logic [QW-1:0]    i_rad,
    output t_ctl             o_ctl,
    output logic [RW-1:0]    o_root
);
    logic [QW-1:0] r_rad  [0:RW];
    logic [RW-1:0] r_root [0:RW];
    logic          r_hit  [0:RW];
    logic [RW:0]   r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[RW-1:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_root[0] <= '0;
            r_hit[0]  <= i_ctl.hit;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW-1:0]   n_cand;
        logic [2*RW-1:0] n_sq;
        assign n_cand = r_root[k] | (RW'(1) << (RW - 1 - k));
        assign n_sq   = n_cand * n_cand;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1]  <= r_rad[k];
                r_root[k+1] <= (QW'(n_sq) <= r_rad[k]) ? n_cand : r_root[k];
                r_hit[k+1]  <= r_hit[k];
            end
        end
    end

    assign o_ctl  = '{vld: r_vld[RW], hit: r_hit[RW]};
    assign o_root = r_root[RW];
endmodule

FILE: hdl/point_segment_distance.sv
// ============================================================================
// point_segment_distance
// Floor of the distance from point P to segment AB (or line AB), pipelined.
// ============================================================================
// Usage:
//   s_axis word: point, end A, end B (six signed Q12.4 coordinates).
//   m_axis word: floor distance (Q.4); tuser flags a perpendicular foot.
//   cfg channel: one bit, line_mode; always ready, write only while idle.
// Pipeline: 5 front stages, 35 divider stages, 18 square-root stages.
// Throughput: one word per cycle while the sink keeps m_axis_tready high.
// Stall: the whole pipeline holds on one shared enable; s_axis_tready
//   drops only while a finished word sits unaccepted on m_axis. Nothing
//   is dropped or repeated.
// Reset: synchronous active low; clears valid bits and line_mode.
// Data path: differences -> products -> sums -> |cross|^2 and len^2 ->
//   bit-serial pipelined division -> pipelined integer square root.
//   End-point case feeds min(|AP|^2,|BP|^2) with divisor 1.
// ============================================================================
module point_segment_distance import psd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_data,      // line_mode
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x, point_y, end_a_x, end_a_y, end_b_x, end_b_y (16 bits each)
    input  logic [95:0]  s_axis_tdata,
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,    // distance [16:0], zero pad
    output logic [0:0]   m_axis_tuser     // interior_hit
);
    logic          r_line_mode;
    logic          w_en;
    t_ctl          w_f_ctl, w_d_ctl, w_s_ctl;
    logic [NW-1:0] w_num;
    logic [PW-1:0] w_den;
    logic [QW-1:0] w_quo;
    logic [RW-1:0] w_root;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_line_mode <= i_cfg_data[0];
        end
    end

    // single pipeline enable: move unless the last stage is holding a word
    assign w_en          = m_axis_tready || !w_s_ctl.vld;
    assign s_axis_tready = w_en;

    psd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (s_axis_tvalid),
        .i_line_mode (r_line_mode),
        .i_px        (s_axis_tdata[15:0]),
        .i_py        (s_axis_tdata[31:16]),
        .i_ax        (s_axis_tdata[47:32]),
        .i_ay        (s_axis_tdata[63:48]),
        .i_bx        (s_axis_tdata[79:64]),
        .i_by        (s_axis_tdata[95:80]),
        .o_ctl       (w_f_ctl),
        .o_num       (w_num),
        .o_den       (w_den)
    );

    psd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_f_ctl),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_ctl   (w_d_ctl),
        .o_quo   (w_quo)
    );

    psd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_d_ctl),
        .i_rad   (w_quo),
        .o_ctl   (w_s_ctl),
        .o_root  (w_root)
    );

    // root is at most 17 bits at this coordinate width: no saturation needed
    assign m_axis_tvalid = w_s_ctl.vld;
    assign m_axis_tdata  = {{(24 - DIST_W){1'b0}}, DIST_W'(w_root)};
    assign m_axis_tuser  = w_s_ctl.hit;
endmodule

FILE: hdl/psd_checker.sv
// ============================================================================
// psd_props
// Port-level checks of the distance block, bound to the top level.
// ============================================================================
`include "point_segment_distance_defines.svh"

module psd_props (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tready,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [23:0]  m_axis_tdata,
    input  logic [0:0]   m_axis_tuser
);
`PSD_ASSERT(a_pad_zero, m_axis_tvalid |-> (m_axis_tdata[23:17] == 7'd0), "pad bits set")
`PSD_ASSERT(a_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled word changed")
`PSD_ASSERT(a_ready, s_axis_tready == (m_axis_tready || !m_axis_tvalid), "ready not tied to output stall")
`PSD_ASSERT_RST(a_reset, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
endmodule

bind point_segment_distance psd_props u_psd_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/psd_checker.sv
// ============================================================================
// psd_checker
// Watches the input, output and config channels of point_segment_distance,
// computes the expected distance and foot flag per accepted word, and
// compares each output word in order with the oldest expectation.
// ============================================================================
`timescale 1ns / 1ps

module psd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [0:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [95:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,
    input  logic [0:0]  i_out_user,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_hits
);
    typedef struct packed {
        logic [16:0] distance;
        logic        hit;
    } t_answer;

    t_answer   answers_q[$];
    logic      line_mode;
    int        mismatches;

    // largest d with d*d*den <= num
    function automatic longint unsigned floor_root(logic [127:0] num, logic [127:0] den);
        longint unsigned d;
        longint unsigned c;
        logic [127:0]    sq;
        d = 0;
        for (int b = 18; b >= 0; b--) begin
            c  = d | (64'd1 << b);
            sq = 128'(c) * 128'(c) * den;
            if (sq <= num) d = c;
        end
        return d;
    endfunction

    function automatic t_answer distance_of(logic [95:0] w, logic lm);
        longint  px, py, ax, ay, bx, by;
        longint  apx, apy, abx, aby, bpx, bpy;
        longint  len2, ap2, bp2, dotp, crs;
        longint unsigned da, db, d;
        t_answer r;
        px = longint'($signed(w[15:0]));  py = longint'($signed(w[31:16]));
        ax = longint'($signed(w[47:32])); ay = longint'($signed(w[63:48]));
        bx = longint'($signed(w[79:64])); by = longint'($signed(w[95:80]));
        apx = px - ax; apy = py - ay;
        bpx = px - bx; bpy = py - by;
        abx = bx - ax; aby = by - ay;
        len2 = abx * abx + aby * aby;
        ap2  = apx * apx + apy * apy;
        dotp = apx * abx + apy * aby;
        crs  = apx * aby - apy * abx;
        if (crs < 0) crs = -crs;
        r.hit = 1'b0;
        if (len2 == 0) begin
            d = floor_root(128'(ap2), 128'd1);
        end else if (lm || (dotp > 0 && dotp < len2)) begin
            d = floor_root(128'(crs) * 128'(crs), 128'(len2));
            r.hit = 1'b1;
        end else begin
            bp2 = bpx * bpx + bpy * bpy;
            da = floor_root(128'(ap2), 128'd1);
            db = floor_root(128'(bp2), 128'd1);
            d = (da < db) ? da : db;
        end
        if (d > 131071) d = 131071;
        r.distance = d[16:0];
        return r;
    endfunction

    assign o_errors  = mismatches;
    assign o_pending = answers_q.size();

    always @(posedge i_clk) begin
        t_answer e;
        if (!i_rst_n) begin
            line_mode  <= 1'b0;
            mismatches <= 0;
            o_results  <= 0;
            o_hits     <= 0;
            answers_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) line_mode <= i_cfg_data[0];
            if (i_in_valid && i_in_ready)
                answers_q.push_back(distance_of(i_in_data, line_mode));
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                o_hits    <= o_hits + i_out_user[0];
                if (answers_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("chk: unexpected word dist=%0d hit=%0d",
                                 i_out_data[16:0], i_out_user[0]);
                    mismatches <= mismatches + 1;
                end else begin
                    e = answers_q.pop_front();
                    if (e.distance !== i_out_data[16:0] || e.hit !== i_out_user[0]
                        || i_out_data[23:17] !== 7'd0) begin
                        if (mismatches < 10)
                            $display("chk: mismatch exp dist=%0d hit=%0d got dist=%0d hit=%0d",
                                     e.distance, e.hit, i_out_data[16:0], i_out_user[0]);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: dv/tb.sv
// ============================================================================
// tb
// Stimulus and verdict for point_segment_distance: directed geometry corners,
// then random words in both modes under varied source and sink pacing.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    localparam int LATENCY = 58;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    int          errors, pending, results, hits;
    int          src_idle_pct;      // chance the source skips a cycle
    int          sink_stall_pct;    // chance the sink holds off
    int          hold_off;          // cycles of forced sink stall left
    logic        hold_go;           // request for a long sink hold-off
    int          words;

    point_segment_distance dut (.*);

    psd_checker chk (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_hits(hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sink pacing, with a forced long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_off      <= 200;
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off      <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // offer one word and hold it until accepted
    task automatic send_word(logic [15:0] px, logic [15:0] py, logic [15:0] ax,
                             logic [15:0] ay, logic [15:0] bx, logic [15:0] by);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {by, bx, ay, ax, py, px};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words++;
    endtask

    task automatic idle_source();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        idle_source();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic set_mode(logic lm);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lm;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly modest coordinates so segment interiors get hit, some full range
    function automatic logic [15:0] rand_coord(int span);
        if (span == 0) return 16'($urandom);
        return 16'($urandom_range(2 * span) - span);
    endfunction

    task automatic random_words(int n);
        logic [15:0] c[6];
        int span;
        for (int i = 0; i < n; i++) begin
            span = ($urandom_range(3) == 0) ? 0 : (($urandom_range(1)) ? 4000 : 200);
            foreach (c[k]) c[k] = rand_coord(span);
            case ($urandom_range(9))
                0: begin c[4] = c[2]; c[5] = c[3]; end          // degenerate segment
                1: begin c[0] = c[2]; c[1] = c[3]; end          // point on end A
                2: begin c[0] = c[4]; c[1] = c[5]; end          // point on end B
                default: ;
            endcase
            send_word(c[0], c[1], c[2], c[3], c[4], c[5]);
        end
    endtask

    task automatic directed(logic lm);
        set_mode(lm);
        send_word(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_word(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_word(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_word(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
        send_word(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_word(16'd16, 16'd50, 16'd0, 16'd0, 16'd100, 16'd0);     // foot inside
        send_word(16'd0, 16'd50, 16'd0, 16'd0, 16'd100, 16'd0);      // foot exactly on A
        send_word(16'd100, 16'd50, 16'd0, 16'd0, 16'd100, 16'd0);    // foot exactly on B
        send_word(-16'sd30, 16'd40, 16'd0, 16'd0, 16'd100, 16'd0);   // beyond A
        send_word(16'd150, -16'sd40, 16'd0, 16'd0, 16'd100, 16'd0);  // beyond B
        send_word(16'd5, 16'd5, 16'd3, 16'd3, 16'd3, 16'd3);         // A equals B
        send_word(16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h0001);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        src_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_go       = 1'b0;
        words         = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed(1'b0);
        directed(1'b1);

        set_mode(1'b0);
        random_words(250);
        // long sink hold-off while the source keeps pushing
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        random_words(150);
        drain();                              // source waits for everything
        src_idle_pct = 87;
        random_words(150);
        set_mode(1'b1);
        src_idle_pct = 0; sink_stall_pct = 87;
        random_words(200);
        src_idle_pct = 34; sink_stall_pct = 34;
        random_words(200);
        set_mode(1'b0);
        src_idle_pct = 0; sink_stall_pct = 0;
        random_words(200);
        src_idle_pct = 34; sink_stall_pct = 34;
        random_words(200);
        drain();

        $display("tb: %0d words in both modes, %0d results, %0d via perpendicular foot",
                 words, results, hits);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: errors");
        $finish;
    end
endmodule
